// ===== sv/lps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LED pattern sequencer package
// Shared constants, sequence state type and pattern tables.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int unsigned LedCount = 8;
  localparam int unsigned PeriodW = 10;
  localparam int unsigned HoldoffW = 8;
  localparam int unsigned PosW = 5;
  localparam int unsigned ModeW = 2;
  localparam int unsigned ModeCount = 4;

  localparam logic [PeriodW-1:0] PeriodReset = 10'd100;
  localparam logic [PeriodW-1:0] PeriodMin = 10'd20;
  localparam logic [PeriodW-1:0] PeriodMax = 10'd800;
  localparam logic [PeriodW-1:0] PeriodStep = 10'd10;
  localparam logic [PeriodW-1:0] ElapsedMax = 10'd1023;
  localparam logic [HoldoffW-1:0] HoldoffTicks = 8'd200;

  localparam logic [LedCount-1:0] TopLed = LedCount'(1) << (LedCount - 1);
  localparam logic [LedCount-1:0] BottomLed = LedCount'(1);

  localparam logic [PosW-1:0] CrashLen = 5'd7;
  localparam logic [PosW-1:0] BilliardLen = 5'd17;
  localparam logic [PosW-1:0] TennisLen = 5'd12;

  typedef enum logic [ModeW-1:0] {
    MODE_SCANNER  = 2'd0,
    MODE_CRASH    = 2'd1,
    MODE_BILLIARD = 2'd2,
    MODE_TENNIS   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [PeriodW-1:0]  elapsed;
    logic [HoldoffW-1:0] holdoff;
    logic [PosW-1:0]     position;
    logic [LedCount-1:0] scanner;
    logic                backward;
    logic [LedCount-1:0] shown;
  } seq_state_t;

  function automatic logic [LedCount-1:0] crash_byte(input logic [2:0] idx);
    logic [LedCount-1:0] v;
    case (idx)
      3'd0: v = 8'h81;
      3'd1: v = 8'h42;
      3'd2: v = 8'h24;
      3'd3: v = 8'h18;
      3'd4: v = 8'h18;
      3'd5: v = 8'h24;
      3'd6: v = 8'h42;
      default: v = 8'h81;
    endcase
    return v;
  endfunction

  function automatic logic [LedCount-1:0] billiard_byte(input logic [4:0] idx);
    logic [LedCount-1:0] v;
    case (idx)
      5'd0:  v = 8'h08;
      5'd1:  v = 8'h09;
      5'd2:  v = 8'h09;
      5'd3:  v = 8'h0B;
      5'd4:  v = 8'h0B;
      5'd5:  v = 8'h09;
      5'd6:  v = 8'h09;
      5'd7:  v = 8'h0B;
      5'd8:  v = 8'h0B;
      5'd9:  v = 8'h09;
      5'd10: v = 8'h0B;
      5'd11: v = 8'h0F;
      5'd12: v = 8'h17;
      5'd13: v = 8'h23;
      5'd14: v = 8'h41;
      5'd15: v = 8'h80;
      5'd16: v = 8'h00;
      default: v = 8'h08;
    endcase
    return v;
  endfunction

  function automatic logic [LedCount-1:0] tennis_byte(input logic [3:0] idx);
    logic [LedCount-1:0] v;
    case (idx)
      4'd0:  v = 8'h85;
      4'd1:  v = 8'h86;
      4'd2:  v = 8'h89;
      4'd3:  v = 8'h89;
      4'd4:  v = 8'h91;
      4'd5:  v = 8'h91;
      4'd6:  v = 8'hA1;
      4'd7:  v = 8'h61;
      4'd8:  v = 8'h91;
      4'd9:  v = 8'h91;
      4'd10: v = 8'h89;
      4'd11: v = 8'h89;
      default: v = 8'h85;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/lps_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LED pattern sequencer step logic
// Computes the next sequence state, period and pattern for one tick.
// ----------------------------------------------------------------------------
module lps_step (
  input  var lps_pkg::seq_state_t         cur,
  input  var lps_pkg::mode_t              mode,
  input  wire [lps_pkg::PeriodW-1:0]      period,
  input  wire                             up_key_held,
  input  wire                             down_key_held,
  output lps_pkg::seq_state_t             nxt,
  output logic [lps_pkg::PeriodW-1:0]     period_next,
  output logic                            fresh
);

  logic [lps_pkg::PeriodW-1:0]  elapsed_inc;
  logic [lps_pkg::HoldoffW-1:0] holdoff_inc;
  logic [lps_pkg::HoldoffW-1:0] holdoff_mid;
  logic [lps_pkg::PeriodW-1:0]  period_mid;
  logic [lps_pkg::LedCount-1:0] scan_v;
  logic [lps_pkg::LedCount-1:0] scan_nx;
  logic                         scan_back;
  logic [lps_pkg::PosW-1:0]     tab_len;
  logic [lps_pkg::PosW-1:0]     tab_pos;
  logic [lps_pkg::PosW-1:0]     tab_pos_inc;
  logic [lps_pkg::LedCount-1:0] tab_byte;

  always_comb begin
    elapsed_inc = (cur.elapsed < lps_pkg::ElapsedMax) ? cur.elapsed + 1'b1 : cur.elapsed;
    holdoff_inc = (cur.holdoff < lps_pkg::HoldoffTicks) ? cur.holdoff + 1'b1 : cur.holdoff;

    scan_v = cur.scanner;
    scan_back = cur.backward;
    if (scan_v == '0) begin
      scan_v = lps_pkg::BottomLed;
      scan_back = 1'b0;
    end
    scan_nx = scan_back ? (scan_v >> 1) : (scan_v << 1);
    if (scan_nx == '0) begin
      scan_nx = lps_pkg::BottomLed;
      scan_back = 1'b0;
    end
    if (scan_nx == lps_pkg::TopLed) begin
      scan_back = 1'b1;
    end
    if (scan_nx == lps_pkg::BottomLed) begin
      scan_back = 1'b0;
    end

    case (mode)
      lps_pkg::MODE_CRASH:    tab_len = lps_pkg::CrashLen;
      lps_pkg::MODE_BILLIARD: tab_len = lps_pkg::BilliardLen;
      default:                tab_len = lps_pkg::TennisLen;
    endcase
    tab_pos = (cur.position < tab_len) ? cur.position : '0;
    tab_pos_inc = tab_pos + 1'b1;
    case (mode)
      lps_pkg::MODE_CRASH:    tab_byte = lps_pkg::crash_byte(tab_pos[2:0]);
      lps_pkg::MODE_BILLIARD: tab_byte = lps_pkg::billiard_byte(tab_pos);
      default:                tab_byte = lps_pkg::tennis_byte(tab_pos[3:0]);
    endcase

    nxt = cur;
    nxt.elapsed = elapsed_inc;
    fresh = 1'b0;
    if (elapsed_inc >= period) begin
      fresh = 1'b1;
      nxt.elapsed = '0;
      if (mode == lps_pkg::MODE_SCANNER) begin
        nxt.shown = scan_v;
        nxt.scanner = scan_nx;
        nxt.backward = scan_back;
      end else begin
        nxt.shown = tab_byte;
        nxt.position = (tab_pos_inc >= tab_len) ? '0 : tab_pos_inc;
      end
    end

    holdoff_mid = holdoff_inc;
    period_mid = period;
    if (down_key_held && holdoff_inc >= lps_pkg::HoldoffTicks
        && period < lps_pkg::PeriodMax) begin
      period_mid = period + lps_pkg::PeriodStep;
      holdoff_mid = '0;
    end
    nxt.holdoff = holdoff_mid;
    period_next = period_mid;
    if (up_key_held && holdoff_mid >= lps_pkg::HoldoffTicks
        && period_mid > lps_pkg::PeriodMin) begin
      period_next = period_mid - lps_pkg::PeriodStep;
      nxt.holdoff = '0;
    end
  end

endmodule
`default_nettype wire

// ===== sv/led_pattern_sequencer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LED pattern sequencer core
// Eight-LED chaser with four modes and a per-mode step period.
// ----------------------------------------------------------------------------
// Each input item is one millisecond tick carrying the key levels, and each
// item yields exactly one result item with the shown pattern, a new-pattern
// flag and the period of the selected mode. An item passes through the
// combinational step logic into the result register, so one item is accepted in
// every cycle while the result register is empty or being taken. Writing the mode
// register restarts the sequence and keeps the periods; write it only while
// no result is pending.
module led_pattern_sequencer_core (
  input  wire         clk,
  input  wire         rst,
  input  wire         pattern_mode_wr_en,
  input  wire  [1:0]  pattern_mode_wr_data,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] up_key_held, [1] down_key_held, [7:2] zero
  input  wire  [7:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [7:0] led_pattern, [8] pattern_new, [18:9] period_ticks, [23:19] zero
  output logic [23:0] m_axis_tdata
);

  lps_pkg::mode_t                 mode;
  logic [lps_pkg::PeriodW-1:0]    period_table [lps_pkg::ModeCount];
  lps_pkg::seq_state_t            state;
  lps_pkg::seq_state_t            state_next;
  logic [lps_pkg::PeriodW-1:0]    period_next;
  logic                           fresh;
  logic                           accept;
  logic [lps_pkg::LedCount-1:0]   out_pattern;
  logic                           out_new;
  logic [lps_pkg::PeriodW-1:0]    out_period;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata = {5'd0, out_period, out_new, out_pattern};

  lps_step u_step (
    .cur           (state),
    .mode          (mode),
    .period        (period_table[mode]),
    .up_key_held   (s_axis_tdata[0]),
    .down_key_held (s_axis_tdata[1]),
    .nxt           (state_next),
    .period_next   (period_next),
    .fresh         (fresh)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= lps_pkg::MODE_SCANNER;
      for (int i = 0; i < lps_pkg::ModeCount; i++) begin
        period_table[i] <= lps_pkg::PeriodReset;
      end
      state.elapsed <= '0;
      state.holdoff <= '0;
      state.position <= '0;
      state.scanner <= lps_pkg::BottomLed;
      state.backward <= 1'b0;
      state.shown <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (pattern_mode_wr_en) begin
        mode <= lps_pkg::mode_t'(pattern_mode_wr_data);
        state.elapsed <= '0;
        state.position <= '0;
        state.scanner <= lps_pkg::BottomLed;
        state.backward <= 1'b0;
        state.shown <= '0;
      end else if (accept) begin
        state <= state_next;
        period_table[mode] <= period_next;
      end
      if (accept) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_pattern <= state_next.shown;
      out_new <= fresh;
      out_period <= period_next;
    end
  end

endmodule
`default_nettype wire

// ===== verif/led_pattern_sequencer_core_tb.sv =====
// ----------------------------------------------------------------------------
// LED pattern sequencer core testbench
// Drives key-level ticks over the input stream and predicts every result item
// with a cycle-free model of the chaser, periods and key hold-off. Each result
// is checked field by field, with random source gaps and sink back-pressure.
// ----------------------------------------------------------------------------
module led_pattern_sequencer_core_tb;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 40;
  localparam int unsigned RANDOM_TICKS_PER_PHASE = 40;

  localparam logic [7*8-1:0] CRASH_SEQ = 56'h42_24_18_18_24_42_81;
  localparam logic [17*8-1:0] BILLIARD_SEQ =
    136'h00_80_41_23_17_0F_0B_09_0B_0B_09_09_0B_0B_09_09_08;
  localparam logic [12*8-1:0] TENNIS_SEQ = 96'h89_89_91_91_61_A1_91_91_89_89_86_85;

  typedef struct packed {
    logic [7:0] led;
    logic       fresh;
    logic [9:0] period;
  } led_frame_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        pattern_mode_wr_en = 1'b0;
  logic [1:0]  pattern_mode_wr_data = 2'd0;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  // [0] up_key_held, [1] down_key_held, [7:2] zero
  logic [7:0]  s_axis_tdata = 8'd0;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] led_pattern, [8] pattern_new, [18:9] period_ticks, [23:19] zero
  wire  [23:0] m_axis_tdata;

  led_frame_t  frame_q [$];
  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned sink_stall_pct = 0;

  logic [9:0]      period_by_mode [lps_pkg::ModeCount];
  logic [9:0]      since_step;
  logic [7:0]      key_wait;
  logic [4:0]      rom_pos;
  logic [7:0]      scan_bits;
  logic            scan_down;
  logic [7:0]      led_shown;
  lps_pkg::mode_t  mode_sel;

  led_pattern_sequencer_core u_top (
    .clk                  (clk),
    .rst                  (rst),
    .pattern_mode_wr_en   (pattern_mode_wr_en),
    .pattern_mode_wr_data (pattern_mode_wr_data),
    .s_axis_tvalid        (s_axis_tvalid),
    .s_axis_tready        (s_axis_tready),
    .s_axis_tdata         (s_axis_tdata),
    .m_axis_tvalid        (m_axis_tvalid),
    .m_axis_tready        (m_axis_tready),
    .m_axis_tdata         (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic int unsigned seq_len(input lps_pkg::mode_t m);
    case (m)
      lps_pkg::MODE_CRASH:    return lps_pkg::CrashLen;
      lps_pkg::MODE_BILLIARD: return lps_pkg::BilliardLen;
      default:                return lps_pkg::TennisLen;
    endcase
  endfunction

  function automatic logic [7:0] seq_byte(input lps_pkg::mode_t m, input int unsigned pos);
    case (m)
      lps_pkg::MODE_CRASH:    return CRASH_SEQ[pos*8 +: 8];
      lps_pkg::MODE_BILLIARD: return BILLIARD_SEQ[pos*8 +: 8];
      default:                return TENNIS_SEQ[pos*8 +: 8];
    endcase
  endfunction

  task automatic restart_chaser();
    rom_pos = '0;
    scan_bits = 8'd1;
    scan_down = 1'b0;
    since_step = '0;
    led_shown = '0;
  endtask

  task automatic reset_chaser();
    for (int k = 0; k < lps_pkg::ModeCount; k++) begin
      period_by_mode[k] = lps_pkg::PeriodReset;
    end
    key_wait = '0;
    mode_sel = lps_pkg::MODE_SCANNER;
    restart_chaser();
  endtask

  task automatic tick_chaser(input logic up, input logic down);
    led_frame_t  f;
    logic [7:0]  v;
    logic [7:0]  nx;
    int unsigned len;
    int unsigned pos;
    if (since_step < lps_pkg::ElapsedMax) since_step = since_step + 1'b1;
    if (key_wait < lps_pkg::HoldoffTicks) key_wait = key_wait + 1'b1;
    f.fresh = 1'b0;
    if (since_step >= period_by_mode[mode_sel]) begin
      if (mode_sel == lps_pkg::MODE_SCANNER) begin
        v = scan_bits;
        if (v == 8'd0) begin
          v = 8'd1;
          scan_down = 1'b0;
        end
        nx = scan_down ? (v >> 1) : (v << 1);
        if (nx == 8'd0) begin
          nx = 8'd1;
          scan_down = 1'b0;
        end
        if (nx == lps_pkg::TopLed) scan_down = 1'b1;
        if (nx == lps_pkg::BottomLed) scan_down = 1'b0;
        scan_bits = nx;
        led_shown = v;
      end else begin
        len = seq_len(mode_sel);
        pos = (rom_pos < len) ? rom_pos : 0;
        led_shown = seq_byte(mode_sel, pos);
        rom_pos = (pos + 1 >= len) ? 5'd0 : 5'(pos + 1);
      end
      since_step = '0;
      f.fresh = 1'b1;
    end
    if (down && key_wait >= lps_pkg::HoldoffTicks
        && period_by_mode[mode_sel] < lps_pkg::PeriodMax) begin
      period_by_mode[mode_sel] = period_by_mode[mode_sel] + lps_pkg::PeriodStep;
      key_wait = '0;
    end
    if (up && key_wait >= lps_pkg::HoldoffTicks
        && period_by_mode[mode_sel] > lps_pkg::PeriodMin) begin
      period_by_mode[mode_sel] = period_by_mode[mode_sel] - lps_pkg::PeriodStep;
      key_wait = '0;
    end
    f.led = led_shown;
    f.period = period_by_mode[mode_sel];
    frame_q.push_back(f);
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("Mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
               result_count, what, got, want);
    end
  endtask

  always @(posedge clk) begin : led_check
    led_frame_t want;
    logic       moved;
    if (rst) begin
      reset_chaser();
      idle_cycles = 0;
    end else begin
      moved = 1'b0;
      if (pattern_mode_wr_en) begin
        mode_sel = lps_pkg::mode_t'(pattern_mode_wr_data);
        restart_chaser();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tick_chaser(s_axis_tdata[0], s_axis_tdata[1]);
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (frame_q.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, 0);
        end else begin
          want = frame_q.pop_front();
          if (m_axis_tdata[7:0] !== want.led) begin
            report_mismatch("led_pattern", m_axis_tdata[7:0], want.led);
          end
          if (m_axis_tdata[8] !== want.fresh) begin
            report_mismatch("pattern_new", m_axis_tdata[8], want.fresh);
          end
          if (m_axis_tdata[18:9] !== want.period) begin
            report_mismatch("period_ticks", m_axis_tdata[18:9], want.period);
          end
        end
        result_count++;
        moved = 1'b1;
      end
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  task automatic send_tick(input logic up, input logic down);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, down, up};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (m_axis_tvalid || frame_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic select_mode(input lps_pkg::mode_t m);
    wait_drained();
    pattern_mode_wr_en <= 1'b1;
    pattern_mode_wr_data <= m;
    @(posedge clk);
    pattern_mode_wr_en <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned sink_pct);
    send_idle_pct = send_pct;
    sink_stall_pct = sink_pct;
  endtask

  // Hold-off is still short after reset, so every key combination must be ignored.
  task automatic test_key_combinations();
    set_idling(0, 0);
    select_mode(lps_pkg::MODE_SCANNER);
    for (int k = 0; k < 20; k++) begin
      send_tick(k[0], k[1]);
    end
  endtask

  // With both keys held the down key acts first and its restart blocks the up key.
  task automatic test_both_keys();
    set_idling(72, 0);
    select_mode(lps_pkg::MODE_BILLIARD);
    repeat (200) send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    repeat (198) send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    repeat (50) send_tick(1'b0, 1'b1);
  endtask

  // Hold the up key so the scanner period shrinks step by step and the scan
  // runs long enough to turn back at the top LED.
  task automatic test_period_keys();
    set_idling(0, 72);
    select_mode(lps_pkg::MODE_SCANNER);
    repeat (900) send_tick(1'b1, 1'b0);
  endtask

  task automatic test_random_ticks();
    int unsigned sent;
    int unsigned seg;
    int unsigned run_left;
    int unsigned pick;
    logic        up;
    logic        down;
    run_left = 0;
    up = 1'b0;
    down = 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_idling(0, 0);
        1: set_idling(72, 0);
        2: set_idling(0, 72);
        default: set_idling(29, 29);
      endcase
      sent = 0;
      while (sent < RANDOM_TICKS_PER_PHASE) begin
        select_mode(lps_pkg::mode_t'($urandom_range(lps_pkg::ModeCount - 1)));
        seg = $urandom_range(60, 20);
        repeat (seg) begin
          if (run_left == 0) begin
            pick = $urandom_range(99);
            up = (pick >= 55 && pick < 70) || pick >= 85;
            down = pick >= 70;
            run_left = $urandom_range(60, 1);
          end
          send_tick(up, down);
          run_left--;
        end
        sent += seg;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_key_combinations();
    test_both_keys();
    test_period_keys();
    test_random_ticks();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && frame_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
